// File: sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define VHE_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("Histogram engine property violated.");
`define VHE_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("Histogram engine forbidden condition seen.");
`else
`define VHE_ASSERT(label, clk, rst, prop)
`define VHE_NEVER(label, clk, rst, expr)
`endif

`endif

// File: sv/vhe_pkg.sv
package vhe_pkg;

   localparam int BINS_DEFAULT = 2048;
   localparam int ADDR_W       = 16;
   localparam int QUEUE_DEPTH  = 4;
   localparam int OUT_DEPTH    = 4;
   localparam int CSR_ADDR_W   = 4;

   localparam logic [1:0] REG_RANGE_MIN = 2'd0;
   localparam logic [1:0] REG_BIN_SCALE = 2'd1;
   localparam logic [1:0] REG_BIN_COUNT = 2'd2;

   localparam logic [15:0] RANGE_MIN_RESET = 16'd0;
   localparam logic [31:0] BIN_SCALE_RESET = 32'd65536;
   localparam logic [11:0] BIN_COUNT_RESET = 12'd2048;
   localparam logic [31:0] COUNT_MAX       = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      OP_ADD  = 2'd0,
      OP_READ = 2'd1,
      OP_SUM  = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      CMD_NONE,
      CMD_ADD,
      CMD_READ,
      CMD_SUM
   } cmd_kind_type;

   typedef struct packed {
      logic [1:0]         operation;
      logic signed [15:0] sample;
      logic [10:0]        first_bin;
      logic [10:0]        last_bin;
      logic               batch_end;
   } req_item_type;

   typedef struct packed {
      logic [47:0] result_value;
      logic [10:0] bin_index;
      logic        skipped;
      logic        invalid;
      logic        batch_done;
   } rsp_item_type;

   typedef struct packed {
      logic signed [15:0] range_min;
      logic [31:0]        bin_scale;
      logic [11:0]        bin_count;
   } cfg_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic [ADDR_W-1:0] addr;
      logic [ADDR_W-1:0] last_addr;
      logic [10:0]       bin_index;
      logic              skipped;
      logic              invalid;
      logic              batch_done;
   } cmd_type;

endpackage

// File: sv/value_histogram_engine_unit.sv
// Uniform-bin histogram engine over signed 16-bit samples with 32-bit saturating counters.
// Items enter through a queue-style port: a transaction happens when push is high and full
// is low. Each item yields one result on the output queue port, shown while empty is low
// and taken when pop is high. Adds, bin reads and range sums come out in order.
// An item passes the front-end registers, the command queue, the back-end register and
// the result queue to reach the result port. Adds and reads sustain one item per cycle
// while no range sum runs and the result queue has room. A range sum holds the counter
// memory's read port over first_bin..last_bin, one bin per cycle; later items wait behind
// it in the command queue. After reset the counter memory is cleared one bin per cycle;
// full stays high during that pass. Configuration writes are taken at any time.
// When the receiver stops popping, the four-entry result queue fills, the back end stops
// issuing, the command queue fills, and full rises; nothing in flight is lost.
// Registers sit at byte addresses 0 (range_min), 4 (bin_scale) and 8 (bin_count) and are
// written by an APB transaction; they should only change while the engine is idle.
`include "assert_macros.svh"

module value_histogram_engine_unit import vhe_pkg::*; #(
   parameter int BINS = BINS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  req_item_type          req_item,
   output logic                  empty,
   input  logic                  pop,
   output rsp_item_type          rsp_item,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   localparam int Q_CNT_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

   cfg_type              cfg_ff, cfg_in;
   logic                 csr_write;
   logic                 accept;
   logic [1:0]           front_inflight;
   logic                 q_push, q_pop, q_empty;
   cmd_type              q_push_data, q_pop_data;
   logic [Q_CNT_W-1:0]   q_count;
   logic                 out_push;
   rsp_item_type         out_push_data;
   logic [OUT_CNT_W-1:0] out_count;
   logic                 clearing;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (paddr[3:2])
            REG_RANGE_MIN: cfg_in.range_min = pwdata[15:0];
            REG_BIN_SCALE: cfg_in.bin_scale = pwdata;
            REG_BIN_COUNT: cfg_in.bin_count = pwdata[11:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
      case (paddr[3:2])
         REG_RANGE_MIN: prdata = {{16{cfg_ff.range_min[15]}}, cfg_ff.range_min};
         REG_BIN_SCALE: prdata = cfg_ff.bin_scale;
         REG_BIN_COUNT: prdata = {20'd0, cfg_ff.bin_count};
         default:       prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.range_min <= RANGE_MIN_RESET;
         cfg_ff.bin_scale <= BIN_SCALE_RESET;
         cfg_ff.bin_count <= BIN_COUNT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign full   = clearing || (32'(q_count) + 32'(front_inflight) >= QUEUE_DEPTH);
   assign accept = push && !full;

   vhe_front #(
      .BINS (BINS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .item     (req_item),
      .cfg      (cfg_ff),
      .q_push   (q_push),
      .q_data   (q_push_data),
      .inflight (front_inflight)
   );

   vhe_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .empty     (q_empty),
      .count     (q_count)
   );

   vhe_back #(
      .BINS (BINS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (q_pop_data),
      .q_pop     (q_pop),
      .out_count (out_count),
      .out_push  (out_push),
      .out_data  (out_push_data),
      .clearing  (clearing)
   );

   vhe_fifo #(
      .WIDTH ($bits(rsp_item_type)),
      .DEPTH (OUT_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_push_data),
      .pop       (pop),
      .pop_data  (rsp_item),
      .empty     (empty),
      .count     (out_count)
   );

   `VHE_ASSERT(a_cmd_queue_room, clock, reset, q_push |-> (32'(q_count) < QUEUE_DEPTH))
   `VHE_ASSERT(a_rsp_queue_room, clock, reset, out_push |-> (32'(out_count) < OUT_DEPTH))
   `VHE_NEVER(a_no_cmd_in_clear, clock, reset, clearing && q_push)

endmodule

// File: sv/vhe_fifo.sv
module vhe_fifo #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   input  logic                       pop,
   output logic [WIDTH-1:0]           pop_data,
   output logic                       empty,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_pop;

   assign empty    = (count_ff == '0);
   assign count    = count_ff;
   assign pop_data = slots_ff[rd_ptr_ff];
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({push, do_pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: sv/vhe_front.sv
module vhe_front import vhe_pkg::*; #(
   parameter int BINS = BINS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  req_item_type item,
   input  cfg_type      cfg,
   output logic         q_push,
   output cmd_type      q_data,
   output logic [1:0]   inflight
);

   logic                f1_v_ff;
   req_item_type        f1_item_ff;
   logic signed [16:0]  f1_diff_ff, f1_diff_in;
   logic                f2_v_ff;
   req_item_type        f2_item_ff;
   logic [47:0]         f2_prod_ff, f2_prod_in;
   logic [31:0]         active_n, bin_ext, first_ext, last_ext;

   assign f1_diff_in = {item.sample[15], item.sample} - {cfg.range_min[15], cfg.range_min};
   assign f2_prod_in = (!f1_diff_ff[16] && f1_diff_ff != '0)
                     ? {32'd0, f1_diff_ff[15:0]} * {16'd0, cfg.bin_scale} : 48'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_v_ff <= 1'b0;
         f2_v_ff <= 1'b0;
      end else begin
         f1_v_ff <= accept;
         f2_v_ff <= f1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      f1_item_ff <= item;
      f1_diff_ff <= f1_diff_in;
      f2_item_ff <= f1_item_ff;
      f2_prod_ff <= f2_prod_in;
   end

   always_comb begin
      if (cfg.bin_count == '0) begin
         active_n = 32'd1;
      end else if ({20'd0, cfg.bin_count} > 32'(BINS)) begin
         active_n = 32'(BINS);
      end else begin
         active_n = {20'd0, cfg.bin_count};
      end
      bin_ext   = (f2_prod_ff[47:16] >= active_n) ? active_n - 32'd1 : f2_prod_ff[47:16];
      first_ext = {21'd0, f2_item_ff.first_bin};
      last_ext  = {21'd0, f2_item_ff.last_bin};

      q_data            = '0;
      q_data.kind       = CMD_NONE;
      q_data.batch_done = f2_item_ff.batch_end;
      case (f2_item_ff.operation)
         OP_ADD: begin
            if (f2_item_ff.sample == '0) begin
               q_data.skipped = 1'b1;
            end else begin
               q_data.kind      = CMD_ADD;
               q_data.addr      = bin_ext[ADDR_W-1:0];
               q_data.bin_index = bin_ext[10:0];
            end
         end
         OP_READ: begin
            if (first_ext < active_n) begin
               q_data.kind = CMD_READ;
               q_data.addr = first_ext[ADDR_W-1:0];
            end else begin
               q_data.invalid = 1'b1;
            end
         end
         OP_SUM: begin
            if (first_ext < last_ext && last_ext < active_n) begin
               q_data.kind      = CMD_SUM;
               q_data.addr      = first_ext[ADDR_W-1:0];
               q_data.last_addr = last_ext[ADDR_W-1:0];
            end else begin
               q_data.invalid = 1'b1;
            end
         end
         default: begin
            q_data.invalid = 1'b1;
         end
      endcase
   end

   assign q_push   = f2_v_ff;
   assign inflight = {1'b0, f1_v_ff} + {1'b0, f2_v_ff};

endmodule

// File: sv/vhe_back.sv
`include "assert_macros.svh"

module vhe_back import vhe_pkg::*; #(
   parameter int BINS = BINS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           q_empty,
   input  cmd_type                        q_data,
   output logic                           q_pop,
   input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
   output logic                           out_push,
   output rsp_item_type                   out_data,
   output logic                           clearing
);

   localparam int              IDX_W    = $clog2(BINS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BINS - 1);

   logic [31:0]      bin_mem_ff [BINS];
   logic             clear_ff, clear_in;
   logic [IDX_W-1:0] clr_addr_ff, clr_addr_in;
   logic             sum_active_ff, sum_active_in;
   logic [IDX_W-1:0] cur_addr_ff, cur_addr_in;
   cmd_type          sum_cmd_ff, sum_cmd_in;
   logic             s2_v_ff, s2_v_in;
   cmd_type          s2_cmd_ff, s2_cmd_in;
   logic             s2_first_ff, s2_first_in;
   logic             s2_last_ff, s2_last_in;
   logic [IDX_W-1:0] s2_addr_ff, s2_addr_in;
   logic [31:0]      rdata_ff;
   logic             byp_ff, byp_in;
   logic [31:0]      byp_data_ff;
   logic [47:0]      acc_ff, sum_val;
   logic [31:0]      cur_val, inc_val;
   logic             issue_ok;
   logic [IDX_W-1:0] rd_addr;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [31:0]      wr_data;

   assign clear_in    = clear_ff && (clr_addr_ff != LAST_IDX);
   assign clr_addr_in = clr_addr_ff + IDX_W'(1);
   assign clearing    = clear_ff;
   assign issue_ok    = !clear_ff && (32'(out_count) + 32'(s2_v_ff) < OUT_DEPTH);

   always_comb begin
      q_pop         = 1'b0;
      s2_v_in       = 1'b0;
      s2_cmd_in     = sum_cmd_ff;
      s2_first_in   = 1'b0;
      s2_last_in    = 1'b0;
      rd_addr       = cur_addr_ff;
      s2_addr_in    = cur_addr_ff;
      sum_active_in = sum_active_ff;
      cur_addr_in   = cur_addr_ff;
      sum_cmd_in    = sum_cmd_ff;
      if (issue_ok) begin
         if (sum_active_ff) begin
            s2_v_in    = 1'b1;
            s2_last_in = (cur_addr_ff == sum_cmd_ff.last_addr[IDX_W-1:0]);
            if (s2_last_in) begin
               sum_active_in = 1'b0;
            end else begin
               cur_addr_in = cur_addr_ff + IDX_W'(1);
            end
         end else if (!q_empty) begin
            q_pop       = 1'b1;
            s2_v_in     = 1'b1;
            s2_cmd_in   = q_data;
            s2_first_in = 1'b1;
            rd_addr     = q_data.addr[IDX_W-1:0];
            s2_addr_in  = q_data.addr[IDX_W-1:0];
            if (q_data.kind == CMD_SUM) begin
               sum_active_in = 1'b1;
               cur_addr_in   = q_data.addr[IDX_W-1:0] + IDX_W'(1);
               sum_cmd_in    = q_data;
            end else begin
               s2_last_in = 1'b1;
            end
         end
      end
   end

   always_comb begin
      cur_val = byp_ff ? byp_data_ff : rdata_ff;
      inc_val = (cur_val == COUNT_MAX) ? cur_val : cur_val + 32'd1;
      sum_val = (s2_first_ff ? 48'd0 : acc_ff) + {16'd0, cur_val};
      if (clear_ff) begin
         wr_en   = 1'b1;
         wr_addr = clr_addr_ff;
         wr_data = '0;
      end else begin
         wr_en   = s2_v_ff && (s2_cmd_ff.kind == CMD_ADD);
         wr_addr = s2_addr_ff;
         wr_data = inc_val;
      end
      byp_in = wr_en && (wr_addr == rd_addr);

      out_push                = s2_v_ff && s2_last_ff;
      out_data.result_value   = (s2_cmd_ff.kind == CMD_READ || s2_cmd_ff.kind == CMD_SUM)
                              ? sum_val : 48'd0;
      out_data.bin_index      = s2_cmd_ff.bin_index;
      out_data.skipped        = s2_cmd_ff.skipped;
      out_data.invalid        = s2_cmd_ff.invalid;
      out_data.batch_done     = s2_cmd_ff.batch_done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff      <= 1'b1;
         clr_addr_ff   <= '0;
         sum_active_ff <= 1'b0;
         s2_v_ff       <= 1'b0;
      end else begin
         clear_ff      <= clear_in;
         clr_addr_ff   <= clr_addr_in;
         sum_active_ff <= sum_active_in;
         s2_v_ff       <= s2_v_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_addr_ff <= cur_addr_in;
      sum_cmd_ff  <= sum_cmd_in;
      s2_cmd_ff   <= s2_cmd_in;
      s2_first_ff <= s2_first_in;
      s2_last_ff  <= s2_last_in;
      s2_addr_ff  <= s2_addr_in;
      byp_ff      <= byp_in;
      byp_data_ff <= wr_data;
      if (s2_v_ff) begin
         acc_ff <= sum_val;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         bin_mem_ff[wr_addr] <= wr_data;
      end
      rdata_ff <= bin_mem_ff[rd_addr];
   end

   `VHE_ASSERT(a_sum_holds_queue, clock, reset, sum_active_ff |-> !q_pop)
   `VHE_ASSERT(a_clear_runs_once, clock, reset, !clear_ff |=> !clear_ff)
   `VHE_ASSERT(a_add_single_beat, clock, reset, (s2_v_ff && s2_cmd_ff.kind == CMD_ADD) |-> (s2_first_ff && s2_last_ff))

endmodule

// File: tb/value_histogram_engine_checker.sv
`timescale 1ns / 100ps

module value_histogram_engine_checker import vhe_pkg::*; #(
   parameter int BINS = BINS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic                  full,
   input  req_item_type          req_item,
   input  logic                  empty,
   input  logic                  pop,
   input  rsp_item_type          rsp_item,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic                  pready,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output int unsigned           fail_count,
   output int unsigned           open_count
);

   cfg_type      cfg_now;
   logic [31:0]  tally [BINS];
   rsp_item_type pending_outcomes [$];

   function automatic int unsigned active_bins();
      if (cfg_now.bin_count == 0) begin
         return 1;
      end
      if (cfg_now.bin_count > BINS) begin
         return BINS;
      end
      return cfg_now.bin_count;
   endfunction

   // Applies one transaction to the model histogram and returns the result it must produce.
   function automatic rsp_item_type bin_outcome(input req_item_type item);
      rsp_item_type       outcome;
      int unsigned        active;
      logic signed [16:0] diff;
      logic [63:0]        scaled;
      int unsigned        slot;
      logic [47:0]        total;
      outcome = '0;
      outcome.batch_done = item.batch_end;
      active = active_bins();
      case (item.operation)
         OP_ADD: begin
            if (item.sample == 0) begin
               outcome.skipped = 1'b1;
            end else begin
               diff = $signed({item.sample[15], item.sample}) -
                      $signed({cfg_now.range_min[15], cfg_now.range_min});
               slot = 0;
               if (diff > 0) begin
                  scaled = ({47'd0, diff} * {32'd0, cfg_now.bin_scale}) >> 16;
                  slot = (scaled >= 64'(active)) ? active - 1 : int'(scaled[31:0]);
               end
               if (tally[slot] != COUNT_MAX) begin
                  tally[slot] = tally[slot] + 1;
               end
               outcome.bin_index = slot[10:0];
            end
         end
         OP_READ: begin
            if (item.first_bin < active) begin
               outcome.result_value = {16'd0, tally[item.first_bin]};
            end else begin
               outcome.invalid = 1'b1;
            end
         end
         OP_SUM: begin
            if (item.first_bin < item.last_bin && item.last_bin < active) begin
               total = '0;
               for (int i = item.first_bin; i <= item.last_bin; i++) begin
                  total = total + {16'd0, tally[i]};
               end
               outcome.result_value = total;
            end else begin
               outcome.invalid = 1'b1;
            end
         end
         default: begin
            outcome.invalid = 1'b1;
         end
      endcase
      return outcome;
   endfunction

   always @(posedge clock) begin
      rsp_item_type wanted;
      if (reset) begin
         cfg_now.range_min = RANGE_MIN_RESET;
         cfg_now.bin_scale = BIN_SCALE_RESET;
         cfg_now.bin_count = BIN_COUNT_RESET;
         foreach (tally[i]) begin
            tally[i] = '0;
         end
         pending_outcomes.delete();
         fail_count = 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[CSR_ADDR_W-1:2])
               REG_RANGE_MIN: cfg_now.range_min = pwdata[15:0];
               REG_BIN_SCALE: cfg_now.bin_scale = pwdata;
               REG_BIN_COUNT: cfg_now.bin_count = pwdata[11:0];
               default: ;
            endcase
         end
         if (push && !full) begin
            pending_outcomes.insert(pending_outcomes.size(), bin_outcome(req_item));
         end
         if (pop && !empty) begin
            if (pending_outcomes.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("%0t: result transaction with nothing expected: value=%0h bin=%0d",
                           $realtime, rsp_item.result_value, rsp_item.bin_index);
               end
            end else begin
               wanted = pending_outcomes.pop_front();
               if (rsp_item.result_value !== wanted.result_value ||
                   rsp_item.bin_index !== wanted.bin_index ||
                   rsp_item.skipped !== wanted.skipped ||
                   rsp_item.invalid !== wanted.invalid ||
                   rsp_item.batch_done !== wanted.batch_done) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("%0t: mismatch: expected value=%0h bin=%0d skip=%0b inv=%0b batch=%0b",
                              $realtime, wanted.result_value, wanted.bin_index, wanted.skipped,
                              wanted.invalid, wanted.batch_done);
                     $display("%0t:           actual value=%0h bin=%0d skip=%0b inv=%0b batch=%0b",
                              $realtime, rsp_item.result_value, rsp_item.bin_index,
                              rsp_item.skipped, rsp_item.invalid, rsp_item.batch_done);
                  end
               end
            end
         end
      end
      open_count = pending_outcomes.size();
   end

endmodule

// File: tb/tb_value_histogram_engine_unit.sv
`timescale 1ns / 100ps

module tb_value_histogram_engine_unit import vhe_pkg::*; ();

   localparam logic [1:0] OP_UNUSED   = 2'd3;
   localparam int         STALL_LIMIT = 20000;

   logic                  clock;
   logic                  reset;
   logic                  push;
   logic                  full;
   req_item_type          req_item;
   logic                  empty;
   logic                  pop;
   rsp_item_type          rsp_item;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [31:0]           pwdata;
   logic [31:0]           prdata;
   logic                  pready;
   int unsigned           fail_count;
   int unsigned           open_count;
   int unsigned           stall_cycles;
   bit                    steady;

   value_histogram_engine_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_item (req_item),
      .empty    (empty),
      .pop      (pop),
      .rsp_item (rsp_item),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   value_histogram_engine_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .req_item   (req_item),
      .empty      (empty),
      .pop        (pop),
      .rsp_item   (rsp_item),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .pready     (pready),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .fail_count (fail_count),
      .open_count (open_count)
   );

   initial begin
      clock = 1'b0;
   end

   always #6 clock = ~clock;

   always @(negedge clock) begin
      pop <= steady || ($urandom_range(0, 99) >= 10);
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("value_histogram_engine_unit regression: fail");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   function automatic req_item_type make_item(input logic [1:0] operation,
                                              input logic [15:0] sample,
                                              input logic [10:0] first_bin,
                                              input logic [10:0] last_bin,
                                              input logic batch_end);
      req_item_type item;
      item.operation = operation;
      item.sample = sample;
      item.first_bin = first_bin;
      item.last_bin = last_bin;
      item.batch_end = batch_end;
      return item;
   endfunction

   // Mostly adds aimed at the configured range and well-formed reads and sums, with some noise.
   function automatic req_item_type random_item(input int unsigned active, input int low);
      req_item_type item;
      int unsigned  pick;
      int unsigned  reach;
      int           value;
      item = make_item(OP_ADD, 16'($urandom), 11'($urandom), 11'($urandom), 1'($urandom));
      pick = $urandom_range(0, 99);
      reach = (active + 1 > 2047) ? 2047 : active + 1;
      if (pick < 55) begin
         pick = $urandom_range(0, 15);
         if (pick == 0) begin
            item.sample = '0;
         end else if (pick >= 4) begin
            value = low + int'($urandom_range(0, 2300)) - 64;
            value = (value > 32767) ? 32767 : ((value < -32768) ? -32768 : value);
            item.sample = value[15:0];
         end
      end else if (pick < 75) begin
         item.operation = OP_READ;
         if ($urandom_range(0, 1) == 0) begin
            item.first_bin = 11'($urandom_range(0, reach));
         end
      end else if (pick < 97) begin
         item.operation = OP_SUM;
         if (active >= 2 && $urandom_range(0, 9) != 0) begin
            item.first_bin = 11'($urandom_range(0, active - 2));
            if ($urandom_range(0, 19) == 0) begin
               item.last_bin = 11'($urandom_range(item.first_bin + 1, active - 1));
            end else begin
               value = item.first_bin + int'($urandom_range(1, 32));
               item.last_bin = 11'((value > int'(active) - 1) ? active - 1 : value);
            end
         end
      end else begin
         item.operation = OP_UNUSED;
      end
      return item;
   endfunction

   task automatic send_item(input req_item_type item);
      if (!steady && $urandom_range(0, 99) < 10) begin
         push <= 1'b0;
         @(negedge clock);
      end
      push <= 1'b1;
      req_item <= item;
      do @(posedge clock); while (full);
      @(negedge clock);
   endtask

   task automatic write_register(input logic [1:0] index, input logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(negedge clock);
   endtask

   task automatic drain_results(input int settle);
      push <= 1'b0;
      while (open_count != 0) @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   task automatic run_phase(input logic [15:0] range_min, input logic [31:0] bin_scale,
                            input logic [11:0] bin_count, input int unsigned count,
                            input bit gapless);
      int unsigned active;
      drain_results(8);
      write_register(REG_RANGE_MIN, {{16{range_min[15]}}, range_min});
      write_register(REG_BIN_SCALE, bin_scale);
      write_register(REG_BIN_COUNT, {20'd0, bin_count});
      active = (bin_count == 0) ? 1 : ((bin_count > 2048) ? 2048 : bin_count);
      steady = gapless;
      repeat (count) send_item(random_item(active, $signed(range_min)));
      steady = 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      push = 1'b0;
      req_item = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      steady = 1'b0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_item(make_item(OP_ADD, 16'sd0, 11'd0, 11'd0, 1'b0));
      send_item(make_item(OP_ADD, 16'sd1, 11'd2047, 11'd2047, 1'b0));
      send_item(make_item(OP_ADD, 16'h7FFF, 11'd0, 11'd0, 1'b0));
      send_item(make_item(OP_ADD, 16'h8000, 11'd0, 11'd0, 1'b0));
      send_item(make_item(OP_ADD, 16'hFFFF, 11'd0, 11'd0, 1'b0));
      send_item(make_item(OP_ADD, 16'sd2047, 11'd0, 11'd0, 1'b0));
      send_item(make_item(OP_ADD, 16'sd2046, 11'd0, 11'd0, 1'b0));
      send_item(make_item(OP_ADD, 16'h5555, 11'd0, 11'd0, 1'b1));
      send_item(make_item(OP_ADD, 16'hAAAA, 11'd0, 11'd0, 1'b0));
      send_item(make_item(OP_READ, 16'sd0, 11'd0, 11'd0, 1'b0));
      send_item(make_item(OP_READ, 16'sd0, 11'd2047, 11'd0, 1'b0));
      send_item(make_item(OP_READ, 16'sd0, 11'd1, 11'd0, 1'b1));
      send_item(make_item(OP_SUM, 16'sd0, 11'd0, 11'd2047, 1'b0));
      send_item(make_item(OP_SUM, 16'sd0, 11'd1, 11'd2047, 1'b0));
      send_item(make_item(OP_SUM, 16'sd0, 11'd5, 11'd5, 1'b0));
      send_item(make_item(OP_SUM, 16'sd0, 11'd6, 11'd2, 1'b0));
      send_item(make_item(OP_UNUSED, 16'sd7, 11'd3, 11'd9, 1'b1));
      repeat (150) send_item(random_item(2048, 0));

      run_phase(16'h8000, 32'h0000_0100, 12'd2048, 190, 1'b0);
      run_phase(16'h7FFF, 32'hFFFF_FFFF, 12'd4095, 190, 1'b0);
      run_phase(-16'sd500, 32'hFFFF_FFFF, 12'd1, 190, 1'b0);
      run_phase(16'sd100, 32'h0000_0000, 12'd0, 190, 1'b0);
      run_phase(-16'sd200, 32'h0002_0000, 12'd16, 190, 1'b0);
      run_phase(16'sd0, 32'h0001_0000, 12'd2048, 220, 1'b1);
      run_phase(-16'sd1, 32'h0000_8000, 12'd2049, 190, 1'b0);
      run_phase(16'($urandom), $urandom_range(0, 32'h0004_0000),
                12'($urandom_range(1, 2048)), 190, 1'b0);

      drain_results(20);
      if (fail_count == 0) begin
         $display("value_histogram_engine_unit regression: pass");
      end else begin
         $display("value_histogram_engine_unit regression: fail");
      end
      $finish;
   end

endmodule
